/* rtl/core/gnam_pkg.sv */
// Shared types, widths and codes for the gauge needle angle mapper.
// No dependencies; the interfaces, the top level, the checker and the testbench import this package.
package gnam_pkg;

    // Default sizing handed to the top level parameters.
    localparam int SEGMENTS_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int SEGIDX_W = 3;
    localparam int SLEW_W   = 31;
    localparam int VAL_W    = 34;   // offset sample, wide enough to never overflow
    localparam int IDX_CMP_W = 7;   // holds any table size up to 64
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    // Command codes of an input item.
    localparam t_cmd CMD_SAMPLE  = 2'd0;
    localparam t_cmd CMD_SEG_WR  = 2'd1;
    localparam t_cmd CMD_RESTART = 2'd2;

    // Configuration register indexes.
    localparam t_reg_idx REG_ENABLE = 3'd0;
    localparam t_reg_idx REG_SLEW   = 3'd1;
    localparam t_reg_idx REG_MIN    = 3'd2;
    localparam t_reg_idx REG_MAX    = 3'd3;
    localparam t_reg_idx REG_START  = 3'd4;
    localparam t_reg_idx REG_LAST   = 3'd5;

    // Saturation bounds of a 32-bit signed angle.
    localparam logic signed [DATA_W-1:0] ANG_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] ANG_MIN = 32'sh8000_0000;

endpackage

/* rtl/core/gnam_in_if.sv */
// Input channel of the gauge needle angle mapper: valid/ready plus one command item.
// Depends on gnam_pkg for field widths.
interface gnam_in_if import gnam_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_cmd                     cmd;
    logic signed [DATA_W-1:0] sample_value;
    logic [SEGIDX_W-1:0]      segment_index;
    logic signed [DATA_W-1:0] segment_threshold;
    logic signed [DATA_W-1:0] segment_divisor;
    logic signed [DATA_W-1:0] segment_offset;

    modport source (
        output valid, cmd, sample_value, segment_index,
               segment_threshold, segment_divisor, segment_offset,
        input  ready
    );
    modport sink (
        input  valid, cmd, sample_value, segment_index,
               segment_threshold, segment_divisor, segment_offset,
        output ready
    );
endinterface

/* rtl/core/gnam_out_if.sv */
// Output channel of the gauge needle angle mapper: valid/ready plus one angle item.
// Depends on gnam_pkg for field widths.
interface gnam_out_if import gnam_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] needle_angle;
    logic                     divide_fault;

    modport source (output valid, needle_angle, divide_fault, input ready);
    modport sink   (input valid, needle_angle, divide_fault, output ready);
endinterface

/* rtl/core/gauge_needle_angle_mapper_top.sv */
// Gauge needle angle mapper: segment table lookup, signed divide, slew limit.
// A segment write or restart item is taken while idle. A sample reads and compares each entry
// up to L, the effective last segment, then goes to the result register with no match, via the
// raw angle step with a zero divisor or overflowing quotient, else via the 32-step divide and sign.
// The input takes the next item in the cycle the result appears; result stalls delay that.
// Synchronous active-low reset clears control state, configuration registers and the current angle.
module gauge_needle_angle_mapper_top import gnam_pkg::*; #(
    parameter int SEGMENTS  = SEGMENTS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gnam_in_if.sink               i_in,
    gnam_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);
    localparam int AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int TW = 3 * DATA_W;
    localparam int MW = VAL_W + FRAC_BITS;
    localparam logic [4:0] CNT_LAST = 5'd31;

    // Sequencer codes.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SGN  = 3'd5;
    localparam logic [2:0] S_RAW  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // Configuration registers.
    logic                     r_enable;
    logic [SLEW_W-1:0]        r_slew;
    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] r_max;
    logic signed [DATA_W-1:0] r_start;
    logic [SEGIDX_W-1:0]      r_last;

    // Datapath and sequencer registers.
    logic [2:0]               r_state,   n_state;
    logic [AW-1:0]            r_idx,     n_idx;
    logic signed [VAL_W-1:0]  r_val,     n_val;
    logic                     r_found,   n_found;
    logic signed [DATA_W-1:0] r_div,     n_div;
    logic signed [DATA_W-1:0] r_off,     n_off;
    logic                     r_fault,   n_fault;
    logic [DATA_W-1:0]        r_dmag,    n_dmag;
    logic [DATA_W:0]          r_rem,     n_rem;
    logic [DATA_W-1:0]        r_lo,      n_lo;
    logic [DATA_W-1:0]        r_quo,     n_quo;
    logic                     r_qneg,    n_qneg;
    logic [4:0]               r_cnt,     n_cnt;
    logic signed [DATA_W-1:0] r_raw,     n_raw;
    logic signed [DATA_W-1:0] r_cur,     n_cur;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_angle, n_out_angle;
    logic                     r_out_fault, n_out_fault;

    // Segment table RAM: {threshold, divisor, offset}.
    logic                 tbl_we;
    logic [AW-1:0]        tbl_waddr;
    logic [TW-1:0]        tbl_wdata;
    logic [TW-1:0]        tbl_rdata;
    logic [IDX_CMP_W-1:0] wr_idx;

    gnam_ram #(
        .WIDTH (TW),
        .DEPTH (SEGMENTS)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (tbl_waddr),
        .i_wr_data (tbl_wdata),
        .i_rd_addr (r_idx),
        .o_rd_data (tbl_rdata)
    );

    // Table write from a segment write item; indexes beyond the table are dropped.
    assign wr_idx    = IDX_CMP_W'(i_in.segment_index);
    assign tbl_waddr = wr_idx[AW-1:0];
    assign tbl_wdata = {i_in.segment_threshold, i_in.segment_divisor, i_in.segment_offset};
    assign tbl_we    = (r_state == S_IDLE) && i_in.valid && (i_in.cmd == CMD_SEG_WR)
                       && (wr_idx < IDX_CMP_W'(SEGMENTS));

    // APB register port.
    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_slew   <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_start  <= '0;
            r_last   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLE: r_enable <= pwdata[0];
                REG_SLEW:   r_slew   <= pwdata[SLEW_W-1:0];
                REG_MIN:    r_min    <= pwdata;
                REG_MAX:    r_max    <= pwdata;
                REG_START:  r_start  <= pwdata;
                REG_LAST:   r_last   <= pwdata[SEGIDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ENABLE: prdata = DATA_W'(r_enable);
            REG_SLEW:   prdata = DATA_W'(r_slew);
            REG_MIN:    prdata = r_min;
            REG_MAX:    prdata = r_max;
            REG_START:  prdata = r_start;
            REG_LAST:   prdata = DATA_W'(r_last);
            default:    prdata = '0;
        endcase
    end

    // Effective last segment, clamped to the table size.
    logic [IDX_CMP_W-1:0] last_eff;
    assign last_eff = (IDX_CMP_W'(r_last) > IDX_CMP_W'(SEGMENTS - 1))
                      ? IDX_CMP_W'(SEGMENTS - 1) : IDX_CMP_W'(r_last);

    // Offset and cap of an incoming sample.
    logic signed [VAL_W-1:0] smp_w, min_w, cap_w, val_off;
    always_comb begin
        smp_w   = VAL_W'(i_in.sample_value);
        min_w   = VAL_W'(r_min);
        cap_w   = VAL_W'(r_max) - min_w;
        val_off = (smp_w <= min_w) ? '0 : smp_w - min_w;
        if (val_off > cap_w) begin
            val_off = cap_w;
        end
    end

    // Fields of the entry read during the table walk.
    logic signed [DATA_W-1:0] rd_thr, rd_div, rd_off;
    assign rd_thr = tbl_rdata[TW-1 -: DATA_W];
    assign rd_div = tbl_rdata[2*DATA_W-1 -: DATA_W];
    assign rd_off = tbl_rdata[DATA_W-1:0];

    // Magnitudes for the divider and the early overflow test.
    logic [VAL_W-1:0]  mag_v;
    logic [MW-1:0]     mag_n;
    logic [DATA_W-1:0] mag_d;
    logic              div_ovf;
    always_comb begin
        mag_v   = r_val[VAL_W-1] ? VAL_W'(-r_val) : VAL_W'(r_val);
        mag_n   = {mag_v, {FRAC_BITS{1'b0}}};
        mag_d   = r_div[DATA_W-1] ? DATA_W'(-r_div) : DATA_W'(r_div);
        div_ovf = (33'(mag_n[MW-1:DATA_W]) >= {1'b0, mag_d});
    end

    // One restoring divide step.
    logic [DATA_W:0] rem_sh;
    logic            rem_ge;
    assign rem_sh = {r_rem[DATA_W-1:0], r_lo[DATA_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_dmag});

    // Raw angle and slew bounds.
    logic signed [DATA_W:0] raw_d, cur_w, slew_lo, slew_hi, ang_w;
    always_comb begin
        raw_d   = (DATA_W+1)'(r_off) - (DATA_W+1)'($signed(r_quo));
        cur_w   = (DATA_W+1)'(r_cur);
        slew_lo = cur_w - $signed({2'b00, r_slew});
        slew_hi = cur_w + $signed({2'b00, r_slew});
        ang_w   = (DATA_W+1)'(r_raw);
        if (ang_w < slew_lo) begin
            ang_w = slew_lo;
        end
        if (ang_w > slew_hi) begin
            ang_w = slew_hi;
        end
    end

    // Sequencer and datapath next state.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_val       = r_val;
        n_found     = r_found;
        n_div       = r_div;
        n_off       = r_off;
        n_fault     = r_fault;
        n_dmag      = r_dmag;
        n_rem       = r_rem;
        n_lo        = r_lo;
        n_quo       = r_quo;
        n_qneg      = r_qneg;
        n_cnt       = r_cnt;
        n_raw       = r_raw;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_angle = r_out_angle;
        n_out_fault = r_out_fault;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.cmd)
                        CMD_RESTART: n_cur = r_start;
                        CMD_SAMPLE: begin
                            if (r_enable) begin
                                n_val   = val_off;
                                n_found = 1'b0;
                                n_fault = 1'b0;
                                n_idx   = '0;
                                n_state = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_val <= VAL_W'(rd_thr)) begin
                    n_found = 1'b1;
                    n_div   = rd_div;
                    n_off   = rd_off;
                end
                if (r_idx == last_eff[AW-1:0]) begin
                    // At or above the last threshold clamps to the last segment.
                    if (r_val >= VAL_W'(rd_thr)) begin
                        n_val   = VAL_W'(rd_thr);
                        n_found = 1'b1;
                        n_div   = rd_div;
                        n_off   = rd_off;
                    end
                    n_state = S_PREP;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_RD;
                end
            end
            S_PREP: begin
                n_qneg = r_val[VAL_W-1] ^ r_div[DATA_W-1];
                if (!r_found) begin
                    n_raw   = '0;
                    n_state = S_OUT;
                end else if (r_div == '0) begin
                    // Zero divisor saturates by the sign of the value.
                    n_fault = 1'b1;
                    if (r_val[VAL_W-1]) begin
                        n_quo = ANG_MIN;
                    end else if (r_val != '0) begin
                        n_quo = ANG_MAX;
                    end else begin
                        n_quo = '0;
                    end
                    n_state = S_RAW;
                end else if (div_ovf) begin
                    n_quo   = n_qneg ? ANG_MIN : ANG_MAX;
                    n_state = S_RAW;
                end else begin
                    n_rem   = 33'(mag_n[MW-1:DATA_W]);
                    n_lo    = mag_n[DATA_W-1:0];
                    n_dmag  = mag_d;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = rem_ge ? (rem_sh - {1'b0, r_dmag}) : rem_sh;
                n_lo  = {r_lo[DATA_W-2:0], 1'b0};
                n_quo = {r_quo[DATA_W-2:0], rem_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_SGN;
                end
            end
            S_SGN: begin
                // Apply the sign and saturate to 32-bit signed.
                if (r_qneg) begin
                    n_quo = (r_quo > DATA_W'(ANG_MIN)) ? ANG_MIN : DATA_W'(-r_quo);
                end else begin
                    n_quo = r_quo[DATA_W-1] ? ANG_MAX : r_quo;
                end
                n_state = S_RAW;
            end
            S_RAW: begin
                if (raw_d > (DATA_W+1)'(ANG_MAX)) begin
                    n_raw = ANG_MAX;
                end else if (raw_d < (DATA_W+1)'(ANG_MIN)) begin
                    n_raw = ANG_MIN;
                end else begin
                    n_raw = raw_d[DATA_W-1:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                // Wait for room in the result register, then commit the angle.
                if (!r_out_valid || o_out.ready) begin
                    n_cur       = ang_w[DATA_W-1:0];
                    n_out_valid = 1'b1;
                    n_out_angle = ang_w[DATA_W-1:0];
                    n_out_fault = r_fault;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_val       <= n_val;
        r_found     <= n_found;
        r_div       <= n_div;
        r_off       <= n_off;
        r_fault     <= n_fault;
        r_dmag      <= n_dmag;
        r_rem       <= n_rem;
        r_lo        <= n_lo;
        r_quo       <= n_quo;
        r_qneg      <= n_qneg;
        r_raw       <= n_raw;
        r_out_angle <= n_out_angle;
        r_out_fault <= n_out_fault;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.needle_angle = r_out_angle;
    assign o_out.divide_fault = r_out_fault;
endmodule

/* rtl/core/gnam_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Self-contained; used for the segment table of the gauge needle angle mapper.
module gnam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                              i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                              o_rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/core/gnam_checker.sv */
// Port-level checks for the gauge needle angle mapper, bound to the top level.
// Depends on gnam_pkg for widths and on gauge_needle_angle_mapper_top for the bind.
module gnam_checker import gnam_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_needle_angle,
    input logic              i_divide_fault,
    input logic              i_pready
);
    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_needle_angle) && $stable(i_divide_fault))
        else $error("result item changed while stalled");

    // No result can appear the cycle after an item is taken into an empty block.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result item appeared too early");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item present after reset");

    // The register port never stalls.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");
endmodule

bind gauge_needle_angle_mapper_top gnam_checker u_gnam_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_needle_angle (o_out.needle_angle),
    .i_divide_fault (o_out.divide_fault),
    .i_pready       (pready)
);

/* tb/gauge_needle_angle_mapper_top_tb.sv */
// Self-checking testbench for the gauge needle angle mapper top level.
// Needs gnam_pkg, gnam_in_if, gnam_out_if, gnam_ram and gauge_needle_angle_mapper_top from the RTL.
module gauge_needle_angle_mapper_top_tb import gnam_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused command code; the block must drop it without a result.
    localparam t_cmd CMD_UNUSED = 2'd3;

    // Idle wait after all expected angles are in, covering any item still in flight.
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        t_cmd                     cmd;
        logic signed [DATA_W-1:0] sample;
        logic [SEGIDX_W-1:0]      index;
        logic signed [DATA_W-1:0] threshold;
        logic signed [DATA_W-1:0] divisor;
        logic signed [DATA_W-1:0] offset;
    } gauge_cmd_t;

    typedef struct {
        logic signed [DATA_W-1:0] angle;
        logic                     fault;
    } needle_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    gnam_in_if  in_ch ();
    gnam_out_if out_ch ();

    gauge_needle_angle_mapper_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the block's registers and state.
    logic                     gauge_on;
    logic [SLEW_W-1:0]        slew;
    logic signed [DATA_W-1:0] level_min;
    logic signed [DATA_W-1:0] level_max;
    logic signed [DATA_W-1:0] restart_angle;
    logic [SEGIDX_W-1:0]      top_seg;
    logic signed [DATA_W-1:0] angle_now;
    logic signed [DATA_W-1:0] seg_thr [SEGMENTS_DEF];
    logic signed [DATA_W-1:0] seg_div [SEGMENTS_DEF];
    logic signed [DATA_W-1:0] seg_off [SEGMENTS_DEF];

    needle_t angle_queue [$];
    int      error_count   = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_request  = 0;
    int      hold_left     = 0;
    int      quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    // Saturate a wide value to the 32-bit signed range.
    function automatic longint clamp_s32(input longint v);
        if (v > longint'(ANG_MAX)) return longint'(ANG_MAX);
        if (v < longint'(ANG_MIN)) return longint'(ANG_MIN);
        return v;
    endfunction

    // Apply one item to the local state; returns 1 when it yields a needle angle.
    function automatic bit predict_needle(input gauge_cmd_t c, output needle_t r);
        longint val, cap, quo, raw, lo, hi, ang, dv;
        int     last, sel, i;
        bit     hit, fault;
        r.angle = '0;
        r.fault = 1'b0;
        case (c.cmd)
            CMD_SEG_WR: begin
                seg_thr[c.index] = c.threshold;
                seg_div[c.index] = c.divisor;
                seg_off[c.index] = c.offset;
                return 0;
            end
            CMD_RESTART: begin
                angle_now = restart_angle;
                return 0;
            end
            CMD_SAMPLE: begin
                if (!gauge_on) return 0;
            end
            default: begin
                return 0;
            end
        endcase

        // Offset by the minimum level, floor at zero, cap at max minus min.
        last = top_seg;
        val = (longint'(c.sample) <= longint'(level_min)) ?
              0 : longint'(c.sample) - longint'(level_min);
        cap = longint'(level_max) - longint'(level_min);
        if (val > cap) val = cap;

        // Highest segment whose threshold is at or above the value.
        hit = 0;
        sel = 0;
        for (i = 0; i <= last; i++) begin
            if (val <= longint'(seg_thr[i])) begin
                hit = 1;
                sel = i;
            end
        end
        if (val >= longint'(seg_thr[last])) begin
            val = seg_thr[last];
            hit = 1;
            sel = last;
        end

        // Offset minus scaled value; a zero divisor saturates and flags a fault.
        fault = 0;
        if (hit) begin
            dv = seg_div[sel];
            if (dv == 0) begin
                fault = 1;
                quo = (val > 0) ? longint'(ANG_MAX) : ((val < 0) ? longint'(ANG_MIN) : 0);
            end else begin
                quo = clamp_s32((val * (longint'(1) << FRAC_BITS_DEF)) / dv);
            end
            raw = clamp_s32(longint'(seg_off[sel]) - quo);
        end else begin
            raw = 0;
        end

        // Slew limit around the previous angle.
        lo = longint'(angle_now) - longint'(slew);
        hi = longint'(angle_now) + longint'(slew);
        ang = raw;
        if (ang < lo) ang = lo;
        if (ang > hi) ang = hi;
        angle_now = ang[DATA_W-1:0];
        r.angle = angle_now;
        r.fault = fault;
        return 1;
    endfunction

    // Random item: mostly samples near the interesting levels, some table writes, a few restarts and unused codes.
    function automatic gauge_cmd_t random_cmd();
        gauge_cmd_t c;
        int unsigned pick;
        c.cmd       = CMD_SAMPLE;
        c.sample    = $urandom();
        c.index     = $urandom_range(SEGMENTS_DEF - 1);
        c.threshold = $urandom();
        c.divisor   = $urandom();
        c.offset    = $urandom();
        pick = $urandom_range(99);
        if (pick < 76) begin
            case ($urandom_range(5))
                0: c.sample = level_min + $urandom_range(8) - 4;
                1: c.sample = level_max + $urandom_range(8) - 4;
                2: c.sample = seg_thr[top_seg] + level_min + $urandom_range(8) - 4;
                3: c.sample = $urandom_range(1) ? ANG_MAX : ANG_MIN;
                4: c.sample = level_min + $urandom_range(32'h0100_0000);
                default: ;
            endcase
        end else if (pick < 90) begin
            c.cmd = CMD_SEG_WR;
            if ($urandom_range(1)) c.threshold = $urandom_range(32'h00FF_FFFF);
            case ($urandom_range(5))
                0: c.divisor = '0;
                1: c.divisor = $urandom_range(1) ? 32'sh0001_0000 : -32'sh0001_0000;
                2: c.divisor = $urandom_range(8) - 4;
                default: ;
            endcase
        end else if (pick < 95) begin
            c.cmd = CMD_RESTART;
        end else begin
            c.cmd = CMD_UNUSED;
        end
        return c;
    endfunction

    // Register write followed by a readback; called from a falling edge.
    task automatic write_reg(input t_reg_idx r, input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] stored;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        stored = v;
        case (r)
            REG_ENABLE: begin
                gauge_on = v[0];
                stored   = {31'd0, v[0]};
            end
            REG_SLEW: begin
                slew   = v[SLEW_W-1:0];
                stored = {1'b0, v[SLEW_W-1:0]};
            end
            REG_MIN:   level_min     = v;
            REG_MAX:   level_max     = v;
            REG_START: restart_angle = v;
            REG_LAST: begin
                top_seg = v[SEGIDX_W-1:0];
                stored  = {29'd0, v[SEGIDX_W-1:0]};
            end
            default: ;
        endcase
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored) begin
            $error("register %0d readback: expected %h, got %h", r, stored, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one item, wait for it to be taken and record what it should produce.
    task automatic send_cmd(input gauge_cmd_t c);
        needle_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.cmd               <= c.cmd;
        in_ch.sample_value      <= c.sample;
        in_ch.segment_index     <= c.index;
        in_ch.segment_threshold <= c.threshold;
        in_ch.segment_divisor   <= c.divisor;
        in_ch.segment_offset    <= c.offset;
        do @(posedge i_clk); while (!in_ch.ready);
        if (predict_needle(c, r)) angle_queue.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic send_sample(input logic signed [DATA_W-1:0] v);
        gauge_cmd_t c;
        c = random_cmd();
        c.cmd    = CMD_SAMPLE;
        c.sample = v;
        send_cmd(c);
    endtask

    task automatic send_segment(input logic [SEGIDX_W-1:0] idx,
                                input logic signed [DATA_W-1:0] thr,
                                input logic signed [DATA_W-1:0] dv,
                                input logic signed [DATA_W-1:0] off);
        gauge_cmd_t c;
        c = random_cmd();
        c.cmd       = CMD_SEG_WR;
        c.index     = idx;
        c.threshold = thr;
        c.divisor   = dv;
        c.offset    = off;
        send_cmd(c);
    endtask

    task automatic send_code(input t_cmd code);
        gauge_cmd_t c;
        c = random_cmd();
        c.cmd = code;
        send_cmd(c);
    endtask

    // Stop offering items, wait for every expected angle, then let the block go idle.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (angle_queue.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // New register setting for a random stretch; levels are mostly ordered.
    task automatic shuffle_config();
        logic signed [DATA_W-1:0] lo_lvl, hi_lvl, tmp;
        case ($urandom_range(3))
            0: lo_lvl = ANG_MIN;
            1: lo_lvl = '0;
            default: lo_lvl = $urandom();
        endcase
        case ($urandom_range(3))
            0: hi_lvl = ANG_MAX;
            1: hi_lvl = '0;
            default: hi_lvl = $urandom();
        endcase
        if ($urandom_range(9) < 7 && hi_lvl < lo_lvl) begin
            tmp    = lo_lvl;
            lo_lvl = hi_lvl;
            hi_lvl = tmp;
        end
        write_reg(REG_ENABLE, $urandom_range(9) != 0);
        case ($urandom_range(3))
            0: write_reg(REG_SLEW, '0);
            1: write_reg(REG_SLEW, 32'h7FFF_FFFF);
            2: write_reg(REG_SLEW, $urandom_range(32'h0004_0000));
            default: write_reg(REG_SLEW, $urandom() & 32'h7FFF_FFFF);
        endcase
        write_reg(REG_MIN, lo_lvl);
        write_reg(REG_MAX, hi_lvl);
        write_reg(REG_START, $urandom());
        write_reg(REG_LAST, $urandom_range(SEGMENTS_DEF - 1));
    endtask

    // Fill every table entry so no sample ever reads an unwritten one.
    task automatic test_segment_table();
        int i;
        for (i = 0; i < SEGMENTS_DEF; i++) begin
            send_segment(i, $urandom(), $urandom() | 32'h0000_0100, $urandom());
        end
        settle();
    endtask

    // Field extremes, divide saturation, zero divisor, clamping, restart, unused code.
    task automatic test_directed_samples();
        write_reg(REG_ENABLE, 1);
        write_reg(REG_SLEW, 32'h7FFF_FFFF);
        write_reg(REG_MIN, '0);
        write_reg(REG_MAX, 32'h7FFF_FFFF);
        write_reg(REG_START, 32'h1234_5678);
        write_reg(REG_LAST, SEGMENTS_DEF - 1);
        send_segment(SEGMENTS_DEF - 1, ANG_MAX, 32'sh0001_0000, '0);
        send_sample(ANG_MIN);
        send_sample(ANG_MAX);
        send_sample(32'sh0001_0000);
        // A tiny divisor saturates the quotient and then the raw angle.
        send_segment(SEGMENTS_DEF - 1, ANG_MAX, 32'sd1, ANG_MIN);
        send_sample(32'sh0010_0000);
        // Zero divisor with a positive and with a zero value.
        send_segment(SEGMENTS_DEF - 1, ANG_MAX, '0, ANG_MAX);
        send_sample(32'sd5);
        send_sample('0);
        // Negative last threshold: the value is clamped below zero.
        send_segment(SEGMENTS_DEF - 1, -32'sh0001_0000, '0, ANG_MAX);
        send_sample(32'sh0003_0000);
        send_segment(SEGMENTS_DEF - 1, -32'sh0001_0000, ANG_MIN, '0);
        send_sample(32'sh0003_0000);
        send_code(CMD_RESTART);
        send_code(CMD_UNUSED);
        send_segment(SEGMENTS_DEF - 1, ANG_MAX, -32'sd1, ANG_MIN);
        send_sample(ANG_MAX);
        settle();
    endtask

    // Disabled samples, restart while disabled, frozen and narrow slew, max below min.
    task automatic test_disable_and_slew();
        write_reg(REG_ENABLE, 0);
        send_sample(32'sh0001_0000);
        send_code(CMD_RESTART);
        settle();
        write_reg(REG_ENABLE, 1);
        write_reg(REG_SLEW, '0);
        send_sample(32'sh7FFF_0000);
        settle();
        write_reg(REG_SLEW, 32'h0000_0100);
        write_reg(REG_MIN, ANG_MAX);
        write_reg(REG_MAX, ANG_MIN);
        write_reg(REG_LAST, 0);
        write_reg(REG_START, ANG_MIN);
        send_sample(ANG_MIN);
        send_code(CMD_RESTART);
        send_sample(ANG_MAX);
        settle();
    endtask

    // Random items over several register settings with the given idle rates.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int settings, input int per_setting);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (settings) begin
            shuffle_config();
            repeat (per_setting) send_cmd(random_cmd());
            settle();
        end
    endtask

    // Output held off for a long stretch while samples keep coming.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_ENABLE, 1);
        hold_request = HOLD_CYCLES;
        repeat (24) send_sample($urandom());
        settle();
    endtask

    // Output ready: random idling, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each output item with the oldest expected angle.
    always @(posedge i_clk) begin : check_needle
        needle_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (angle_queue.size() == 0) begin
                $error("unexpected output item: angle %0d fault %0b",
                       out_ch.needle_angle, out_ch.divide_fault);
                error_count++;
            end else begin
                want = angle_queue.pop_front();
                if (out_ch.needle_angle !== want.angle) begin
                    $error("needle_angle: expected %0d, got %0d",
                           want.angle, out_ch.needle_angle);
                    error_count++;
                end
                if (out_ch.divide_fault !== want.fault) begin
                    $error("divide_fault: expected %0b, got %0b",
                           want.fault, out_ch.divide_fault);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("gauge_needle_angle_mapper_top_tb: errors");
            $finish;
        end
    end

    initial begin
        int i;
        in_ch.valid             = 1'b0;
        in_ch.cmd               = CMD_SAMPLE;
        in_ch.sample_value      = '0;
        in_ch.segment_index     = '0;
        in_ch.segment_threshold = '0;
        in_ch.segment_divisor   = '0;
        in_ch.segment_offset    = '0;
        out_ch.ready            = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;

        // State after reset.
        gauge_on      = 1'b0;
        slew          = '0;
        level_min     = '0;
        level_max     = '0;
        restart_angle = '0;
        top_seg       = '0;
        angle_now     = '0;
        for (i = 0; i < SEGMENTS_DEF; i++) begin
            seg_thr[i] = '0;
            seg_div[i] = '0;
            seg_off[i] = '0;
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_segment_table();
        test_directed_samples();
        test_disable_and_slew();
        test_random_traffic(29, 79, 4, 60);
        test_random_traffic(79, 29, 4, 60);
        test_random_traffic(0, 0, 4, 60);
        test_output_backpressure();

        if (error_count == 0) begin
            $display("gauge_needle_angle_mapper_top_tb: clean");
        end else begin
            $display("gauge_needle_angle_mapper_top_tb: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/gnam_pkg.sv
rtl/core/gnam_in_if.sv
rtl/core/gnam_out_if.sv
rtl/core/gnam_ram.sv
rtl/core/gauge_needle_angle_mapper_top.sv
rtl/core/gnam_checker.sv
tb/gauge_needle_angle_mapper_top_tb.sv
